// ===== design/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache controller.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int ADDR_W = 32;
    localparam int BLK_W  = 28;
    localparam int TOT_W  = 10;
    localparam int WBC_W  = 9;
    localparam int WAY_W  = 3;

    // register indexes on the configuration port
    localparam int REG_FIRST = 0;
    localparam int REG_NEXT  = 1;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // one sub-access as it travels from front to back
    typedef struct packed {
        logic              is_write;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_sub;

endpackage

// ===== design/salc_ram.sv =====
// ----------------------------------------------------------------------------
// salc_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/salc_front.sv =====
// ----------------------------------------------------------------------------
// salc_front
// Accepts items and splits a block-crossing word into byte sub-accesses,
// one per cycle into the queue while the queue is not full.
// ----------------------------------------------------------------------------
module salc_front #(
    parameter int BLOCK_BYTES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_kind,
    input  logic [31:0]    i_address,
    input  logic           i_access_size,
    output logic           o_sub_valid,
    input  logic           i_sub_stall,
    output salc_pkg::t_sub o_sub
);
    import salc_pkg::*;

    localparam int OFF_W = $clog2(BLOCK_BYTES);

    logic              r_busy;
    logic              r_write;
    logic [ADDR_W-1:0] r_addr;
    logic [1:0]        r_step;
    logic [1:0]        r_count;   // sub-accesses minus one
    logic [OFF_W:0]    w_off_end;
    logic              w_cross;
    logic              w_fire;

    // word crosses the block when offset + 4 exceeds the block size
    assign w_off_end = {1'b0, i_address[OFF_W-1:0]} + (OFF_W+1)'(4);
    assign w_cross   = i_access_size && (w_off_end > (OFF_W+1)'(BLOCK_BYTES));

    assign o_stall     = r_busy;
    assign o_sub_valid = r_busy;
    assign w_fire      = r_busy && !i_sub_stall;

    // reads touch first and last byte, writes all four
    always_comb begin
        o_sub.is_write = r_write;
        o_sub.last     = (r_step == r_count);
        if (!r_write && r_step != 2'd0) begin
            o_sub.addr = r_addr + ADDR_W'(3);
        end else begin
            o_sub.addr = r_addr + ADDR_W'(r_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (!r_busy && i_valid) begin
            r_busy  <= 1'b1;
            r_step  <= '0;
            r_write <= i_kind;
            r_addr  <= i_address;
            r_count <= !w_cross ? 2'd0 : (i_kind == KIND_WRITE ? 2'd3 : 2'd1);
        end else if (w_fire) begin
            if (r_step == r_count) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step + 2'd1;
        end
    end
endmodule

// ===== design/salc_queue.sv =====
// ----------------------------------------------------------------------------
// salc_queue
// Two-entry queue that decouples the front splitter from the tag engine.
// ----------------------------------------------------------------------------
module salc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  salc_pkg::t_sub i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output salc_pkg::t_sub o_data
);
    import salc_pkg::*;

    t_sub       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ===== design/salc_back.sv =====
// ----------------------------------------------------------------------------
// salc_back
// Tag engine: reads one set, resolves hit or victim, writes the set back
// with LRU update and presents the result in an output register.
// ----------------------------------------------------------------------------
module salc_back #(
    parameter int BLOCK_BYTES = 16,
    parameter int NUM_SETS    = 16,
    parameter int NUM_WAYS    = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [7:0]             i_first,
    input  logic [3:0]             i_next,
    input  logic                   i_sub_valid,
    output logic                   o_sub_stall,
    input  salc_pkg::t_sub         i_sub,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_hit,
    output logic [9:0]             o_total_cycles,
    output logic                   o_did_writeback,
    output logic [8:0]             o_writeback_cycles,
    output logic [27:0]            o_victim_block,
    output logic [27:0]            o_refill_block,
    output logic [2:0]             o_way_used,
    output logic                   o_last
);
    import salc_pkg::*;

    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SETB   = $clog2(NUM_SETS);
    localparam int TAG_W  = ADDR_W - OFF_W - SETB;
    localparam int RANK_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int WIDX_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int EXTRA  = BLOCK_BYTES / 4 - 1;

    // engine states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] r_state;
    t_sub       r_sub;

    // per-way state in flip-flops (valid, dirty, rank reset), tags in RAM
    logic [NUM_WAYS-1:0]   r_valid [NUM_SETS];
    logic [NUM_WAYS-1:0]   r_dirty [NUM_SETS];
    logic [RANK_W-1:0]     r_rank  [NUM_SETS][NUM_WAYS];
    logic [TAG_W-1:0]      w_tag_rd [NUM_WAYS];
    logic [NUM_WAYS-1:0]   w_tag_we;

    logic [OFF_W+SETB+TAG_W-1:0] w_blk_full;
    logic [SET_W-1:0]  w_set;
    logic [TAG_W-1:0]  w_tag;
    logic [SET_W-1:0]  r_set;
    logic [TAG_W-1:0]  r_tag;

    assign w_set = (NUM_SETS > 1) ? SET_W'(i_sub.addr >> OFF_W) : '0;
    assign r_tag = TAG_W'(r_sub.addr >> (OFF_W + SETB));
    assign w_tag = r_tag;
    assign w_blk_full = '0;

    always_comb begin
        r_set = (NUM_SETS > 1) ? SET_W'(r_sub.addr >> OFF_W) : '0;
    end

    // tag memories, one per way; the read follows the held sub-access once popped
    for (genvar g = 0; g < NUM_WAYS; g++) begin : g_tag
        salc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_SETS > 1 ? NUM_SETS : 2)) u_tag (
            .i_clk  (i_clk),
            .i_we   (w_tag_we[g]),
            .i_waddr(($clog2(NUM_SETS > 1 ? NUM_SETS : 2))'(r_set)),
            .i_wdata(w_tag),
            .i_raddr(($clog2(NUM_SETS > 1 ? NUM_SETS : 2))'(
                         (r_state == ST_IDLE) ? w_set : r_set)),
            .o_rdata(w_tag_rd[g])
        );
    end

    // hit / victim resolution
    logic                found;
    logic [WIDX_W-1:0]   way;
    logic                pick;
    logic [RANK_W-1:0]   worst;
    logic [RANK_W-1:0]   w_r;
    logic                wb;
    logic [15:0]         xfer;
    logic [16:0]         total;
    logic [31:0]         blk;
    logic [31:0]         vblk;

    always_comb begin
        found = 1'b0;
        way   = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (r_valid[r_set][w] && w_tag_rd[w] == r_tag) begin
                found = 1'b1;
                way   = WIDX_W'(w);
            end
        end
        pick = 1'b0;
        if (!found) begin
            for (int w = NUM_WAYS - 1; w >= 0; w--) begin
                if (!r_valid[r_set][w]) begin
                    pick = 1'b1;
                    way  = WIDX_W'(w);
                end
            end
            if (!pick) begin
                worst = '0;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (w == 0 || r_rank[r_set][w] > worst) begin
                        worst = r_rank[r_set][w];
                        way   = WIDX_W'(w);
                    end
                end
            end
        end
        worst = r_rank[r_set][way];
        w_r   = worst;
        wb    = !found && r_valid[r_set][way] && r_dirty[r_set][way];
        xfer  = 16'(i_first) + 16'(i_next) * 16'(EXTRA);
        total = 17'd1 + 17'(xfer) + (wb ? 17'(xfer) : 17'd0);
        blk   = r_sub.addr >> OFF_W;
        vblk  = (32'(w_tag_rd[way]) << SETB) | 32'(r_set);
    end

    assign w_tag_we = (r_state == ST_EVAL && !found)
                      ? (NUM_WAYS'(1) << way) : '0;

    assign o_sub_stall = (r_state != ST_IDLE);
    assign o_valid     = (r_state == ST_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int s = 0; s < NUM_SETS; s++) begin
                r_valid[s] <= '0;
                r_dirty[s] <= '0;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    r_rank[s][w] <= RANK_W'(w);
                end
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_sub_valid) begin
                        r_sub   <= i_sub;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: r_state <= ST_EVAL;
                ST_EVAL: begin
                    // set update and result capture
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        if (r_rank[r_set][w] < w_r) begin
                            r_rank[r_set][w] <= r_rank[r_set][w] + RANK_W'(1);
                        end
                    end
                    r_rank[r_set][way] <= '0;
                    r_valid[r_set][way] <= 1'b1;
                    if (found) begin
                        if (r_sub.is_write == KIND_WRITE) r_dirty[r_set][way] <= 1'b1;
                    end else begin
                        r_dirty[r_set][way] <= r_sub.is_write;
                    end
                    o_hit              <= found;
                    o_total_cycles     <= found ? 10'd1
                                          : (total > 17'd1023 ? 10'd1023 : total[9:0]);
                    o_did_writeback    <= wb;
                    o_writeback_cycles <= !wb ? 9'd0
                                          : (xfer > 16'd511 ? 9'd511 : xfer[8:0]);
                    o_victim_block     <= wb ? vblk[27:0] : 28'd0;
                    o_refill_block     <= found ? 28'd0 : blk[27:0];
                    o_way_used         <= WAY_W'(way);
                    o_last             <= r_sub.last;
                    r_state            <= ST_OUT;
                end
                ST_OUT: begin
                    if (!i_stall) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    logic unused;
    assign unused = ^w_blk_full;
endmodule

// ===== design/set_assoc_lru_cache_controller.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_controller
// Tag, state and timing engine of a write-back set-associative LRU cache.
// ----------------------------------------------------------------------------
// Each sub-access passes through the tag engine in order: queue pop, tag
// RAM read, evaluate and set update, result beat. The engine takes no new
// sub-access until the result beat of the last one is taken; its single
// set read-modify-write bounds the rate. The front splitter feeds a
// two-entry queue so it keeps working while a result beat waits. Valid and
// dirty are flip-flops cleared by reset, LRU ranks flip-flops reset to the
// way index; tags sit in one RAM per way and need no clearing pass.
module set_assoc_lru_cache_controller #(
    parameter int BLOCK_BYTES = 16,
    parameter int NUM_SETS    = 16,
    parameter int NUM_WAYS    = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [31:0] i_address,
    input  logic        i_access_size,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic [9:0]  o_total_cycles,
    output logic        o_did_writeback,
    output logic [8:0]  o_writeback_cycles,
    output logic [27:0] o_victim_block,
    output logic [27:0] o_refill_block,
    output logic [2:0]  o_way_used,
    output logic        o_last
);
    import salc_pkg::*;

    logic [7:0] r_first;
    logic [3:0] r_next;
    logic       w_wr;

    // configuration registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 8'd8;
            r_next  <= 4'd2;
        end else if (w_wr) begin
            if (paddr[2] == 1'(REG_FIRST)) r_first <= pwdata[7:0];
            else                           r_next  <= pwdata[3:0];
        end
    end
    always_comb begin
        prdata = (paddr[2] == 1'(REG_NEXT)) ? {28'd0, r_next} : {24'd0, r_first};
    end

    t_sub f_sub, q_sub;
    logic f_valid, f_stall, q_valid, q_stall;

    salc_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_kind, .i_address, .i_access_size,
        .o_sub_valid(f_valid), .i_sub_stall(f_stall), .o_sub(f_sub)
    );

    salc_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_stall(f_stall), .i_data(f_sub),
        .o_valid(q_valid), .i_stall(q_stall), .o_data(q_sub)
    );

    salc_back #(.BLOCK_BYTES(BLOCK_BYTES), .NUM_SETS(NUM_SETS),
                .NUM_WAYS(NUM_WAYS)) u_back (
        .i_clk, .i_rst_n, .i_first(r_first), .i_next(r_next),
        .i_sub_valid(q_valid), .o_sub_stall(q_stall), .i_sub(q_sub),
        .o_valid, .i_stall, .o_hit, .o_total_cycles, .o_did_writeback,
        .o_writeback_cycles, .o_victim_block, .o_refill_block, .o_way_used, .o_last
    );

    // a hit never reports a writeback
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_did_writeback) else $error("hit with writeback");
    // a hit reports the hit cost on o_total_cycles
    a_hit_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_total_cycles == 10'd1) else $error("hit cost");
    // way stays in range
    a_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_way_used) < NUM_WAYS) else $error("way range");
endmodule
